FILE: hdl/sv39w_pkg.sv
// shared types and constants for the sv39 page table walker
`timescale 1ns / 1ps

package sv39w_pkg;

  localparam int TABLE_PAGES_DEF  = 16;
  localparam int ENTRIES_PER_PAGE = 512;
  localparam int LEVELS           = 3;
  localparam int SLOT_W           = 9;
  localparam int PPN_W            = 44;
  localparam int PA_W             = 56;
  localparam int VPN_W            = LEVELS * SLOT_W;
  localparam int CFG_ADDR_W       = 4;
  localparam int CFG_DATA_W       = 64;

  localparam logic [1:0] TOP_LEVEL = 2'(LEVELS - 1);

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_TOO_LARGE = 3'd1,
    STAT_INVALID   = 3'd2,
    STAT_NOT_USER  = 3'd3,
    STAT_OUTSIDE   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    WS_IDLE,
    WS_WALK,
    WS_HOLD
  } walk_state_t;

  typedef enum logic {
    KIND_WRITE     = 1'b0,
    KIND_TRANSLATE = 1'b1
  } kind_t;

  typedef enum logic {
    REG_ROOT   = 1'b0,
    REG_WINDOW = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    status_t           status;
    logic [PA_W-1:0]   pa;
    logic [1:0]        level;
  } res_t;

endpackage

FILE: hdl/sv39w_table_mem.sv
// page table memory, one write port and one registered read port
`timescale 1ns / 1ps

module sv39w_table_mem import sv39w_pkg::*; #(
  parameter int DEPTH  = TABLE_PAGES_DEF * ENTRIES_PER_PAGE,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [63:0]       wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [63:0]       rd_data
);

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/sv39w_walk.sv
// walk sequencer: request decode, level walk over table memory, result register
`timescale 1ns / 1ps

module sv39w_walk import sv39w_pkg::*; #(
  parameter int TABLE_PAGES = TABLE_PAGES_DEF,
  parameter int ADDR_W      = $clog2(TABLE_PAGES * ENTRIES_PER_PAGE)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [PPN_W-1:0]  root_page,
  input  logic [PPN_W-1:0]  base_page,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [12:0]       in_word_index,
  input  logic [63:0]       in_entry_value,
  input  logic [63:0]       in_virtual_address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic [PA_W-1:0]   out_phys_addr,
  output logic [1:0]        out_fault_level,
  output logic              mem_wr_en,
  output logic [ADDR_W-1:0] mem_wr_addr,
  output logic [63:0]       mem_wr_data,
  output logic              mem_rd_en,
  output logic [ADDR_W-1:0] mem_rd_addr,
  input  logic [63:0]       mem_rd_data
);

  localparam int MEM_WORDS = TABLE_PAGES * ENTRIES_PER_PAGE;

  walk_state_t       state_r, state_nxt;
  logic [1:0]        level_r, level_nxt;
  logic [VPN_W-1:0]  vpn_r, vpn_nxt;
  res_t              held_r;
  res_t              out_r;
  logic              out_valid_r;

  logic              accept;
  logic              out_free;
  logic              fin;
  res_t              fin_res;
  logic [PPN_W-1:0]  chk_page;
  logic [PPN_W:0]    chk_diff;
  logic              chk_outside;
  logic [1:0]        next_level;
  logic [SLOT_W-1:0] slot;
  logic [31:0]       wr_index;
  logic [PPN_W+SLOT_W-1:0] rd_full;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != WS_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // table page check against the memory window
  assign chk_page    = (state_r == WS_IDLE) ? root_page : mem_rd_data[53:10];
  assign chk_diff    = {1'b0, chk_page} - {1'b0, base_page};
  assign chk_outside = chk_diff[PPN_W] ||
                       (chk_diff[PPN_W-1:0] >= PPN_W'(TABLE_PAGES));

  assign next_level = (state_r == WS_IDLE) ? TOP_LEVEL : level_r - 2'd1;
  assign vpn_nxt    = (state_r == WS_IDLE) ? in_virtual_address[38:12] : vpn_r;

  always_comb begin
    unique case (next_level)
      2'd2:    slot = vpn_nxt[26:18];
      2'd1:    slot = vpn_nxt[17:9];
      default: slot = vpn_nxt[8:0];
    endcase
  end

  assign rd_full     = {chk_diff[PPN_W-1:0], slot};
  assign mem_rd_addr = rd_full[ADDR_W-1:0];

  assign wr_index    = 32'(in_word_index);
  assign mem_wr_addr = wr_index[ADDR_W-1:0];
  assign mem_wr_data = in_entry_value;

  // request outcome for this cycle
  always_comb begin
    fin       = 1'b0;
    fin_res   = '{status: STAT_OK, pa: '0, level: 2'd0};
    mem_wr_en = 1'b0;
    mem_rd_en = 1'b0;
    level_nxt = level_r;
    unique case (state_r)
      WS_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_WRITE) begin
            mem_wr_en = (wr_index < 32'(MEM_WORDS));
            fin       = 1'b1;
          end else if (in_virtual_address[63:38] != '0) begin
            fin            = 1'b1;
            fin_res.status = STAT_TOO_LARGE;
            fin_res.level  = TOP_LEVEL;
          end else if (chk_outside) begin
            fin            = 1'b1;
            fin_res.status = STAT_OUTSIDE;
            fin_res.level  = TOP_LEVEL;
          end else begin
            mem_rd_en = 1'b1;
            level_nxt = TOP_LEVEL;
          end
        end
      end
      WS_WALK: begin
        if (!mem_rd_data[0]) begin
          fin            = 1'b1;
          fin_res.status = STAT_INVALID;
          fin_res.level  = level_r;
        end else if (level_r == 2'd0) begin
          fin = 1'b1;
          if (!mem_rd_data[4]) begin
            fin_res.status = STAT_NOT_USER;
          end else begin
            fin_res.pa = {mem_rd_data[53:10], 12'b0};
          end
        end else if (chk_outside) begin
          fin            = 1'b1;
          fin_res.status = STAT_OUTSIDE;
          fin_res.level  = next_level;
        end else begin
          mem_rd_en = 1'b1;
          level_nxt = next_level;
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      WS_IDLE: begin
        if (accept) begin
          if (fin) begin
            state_nxt = out_free ? WS_IDLE : WS_HOLD;
          end else begin
            state_nxt = WS_WALK;
          end
        end
      end
      WS_WALK: begin
        if (fin) begin
          state_nxt = out_free ? WS_IDLE : WS_HOLD;
        end
      end
      WS_HOLD: begin
        if (out_free) begin
          state_nxt = WS_IDLE;
        end
      end
      default: state_nxt = WS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= WS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_free) begin
        out_valid_r <= fin || (state_r == WS_HOLD);
      end
    end
  end

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
    vpn_r   <= vpn_nxt;
    if (fin) begin
      held_r <= fin_res;
    end
    if (out_free) begin
      out_r <= (state_r == WS_HOLD) ? held_r : fin_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_phys_addr   = out_r.pa;
  assign out_fault_level = out_r.level;

endmodule

FILE: hdl/sv39_page_table_walker_core.sv
// Sv39 page table walker top level: configuration registers, walker and table memory
//
// Requests enter on in_* and each yields one result on out_*. A write request
// (in_kind 0) stores one 64-bit entry into table memory and has its result
// registered at acceptance unless the output is stalled. A translate request
// reads table memory once per level through the single registered read port,
// and the block takes one request at a time, accepting no new one until a walk
// is through; unless the output stalls, it takes one per cycle for writes and
// early faults. Table memory holds TABLE_PAGES pages of 512 entries and is not
// cleared at reset; entries must be written before a walk reads them. The root
// page number lives at byte address 0 and the window base page at byte address 8
// of the 64-bit configuration port; change them only while no request is in flight.
`timescale 1ns / 1ps

module sv39_page_table_walker_core import sv39w_pkg::*; #(
  parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [12:0]           in_word_index,
  input  logic [63:0]           in_entry_value,
  input  logic [63:0]           in_virtual_address,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_status,
  output logic [PA_W-1:0]       out_phys_addr,
  output logic [1:0]            out_fault_level
);

  localparam int DEPTH  = TABLE_PAGES * ENTRIES_PER_PAGE;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [PPN_W-1:0]  root_r;
  logic [PPN_W-1:0]  base_r;
  logic              cfg_wr;
  cfg_reg_t          cfg_sel;

  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [63:0]       mem_wr_data;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic [63:0]       mem_rd_data;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
      base_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_ROOT:   root_r <= cfg_pwdata[PPN_W-1:0];
        REG_WINDOW: base_r <= cfg_pwdata[PPN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_ROOT:   cfg_prdata = CFG_DATA_W'(root_r);
      REG_WINDOW: cfg_prdata = CFG_DATA_W'(base_r);
      default:    cfg_prdata = '0;
    endcase
  end

  sv39w_walk #(
    .TABLE_PAGES (TABLE_PAGES),
    .ADDR_W      (ADDR_W)
  ) u_walk (
    .clk                (clk),
    .rst_n              (rst_n),
    .root_page          (root_r),
    .base_page          (base_r),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_word_index      (in_word_index),
    .in_entry_value     (in_entry_value),
    .in_virtual_address (in_virtual_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_phys_addr      (out_phys_addr),
    .out_fault_level    (out_fault_level),
    .mem_wr_en          (mem_wr_en),
    .mem_wr_addr        (mem_wr_addr),
    .mem_wr_data        (mem_wr_data),
    .mem_rd_en          (mem_rd_en),
    .mem_rd_addr        (mem_rd_addr),
    .mem_rd_data        (mem_rd_data)
  );

  sv39w_table_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule
